// ----- rtl/bba_pkg.sv -----
// package: types, constants and helpers for the buddy block allocator
package bba_pkg;

  localparam int unsigned TopOrderDefault    = 16;
  localparam int unsigned LeastOrderDefault  = 5;
  localparam int unsigned HeaderBytesDefault = 4;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoSpace = 2'd1,
    StatusBadFree = 2'd2
  } status_e;

  typedef enum logic {
    FuncAlloc = 1'b0,
    FuncFree  = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [4:0]  block_order;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScanChk,
    StSplit,
    StAllocDone,
    StFreeRd,
    StFreeChk,
    StMergeRd,
    StMergeChk,
    StFreeDone,
    StClear,
    StOut
  } state_e;

  // floor log2 of a 33-bit value (zero for zero)
  function automatic logic [5:0] flog2(input logic [32:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/bba_tree_mem.sv -----
// free tree memory: one bit per node, one read and one write port
module bba_tree_mem #(
  parameter int unsigned Nodes = 4095,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);
  logic mem [Nodes];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/bba_leaf_mem.sv -----
// per-leaf allocation record: valid bit and order
module bba_leaf_mem #(
  parameter int unsigned Leaves = 2048,
  parameter int unsigned AddrW  = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [5:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [5:0]       rdata_o
);
  logic [5:0] mem [Leaves];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// top level: buddy block allocator with tree and leaf memories
//
// channel   dir  payload  handshake
// req       in   req_t    req_valid_i / req_ready_o
// rsp       out  rsp_t    rsp_valid_o / rsp_ready_i
// cfg       in   32-bit   cfg_valid_i / cfg_ready_o (heap_base)
//
// after reset a clearing pass writes every tree node and leaf record
// before the first beat is taken
// allocate: tree nodes are scanned from the needed order upward
// (lowest address first), then the found block is split down to the needed
// order one split at a time, and the leaf record is written last
// free: a bad address or unknown pointer gives a failed result; otherwise
// blocks merge upward while the buddy is free, stopping at the root
// one item at a time; the result sits in an output register until taken,
// and the next request beat can be taken in the cycle after the result beat
module buddy_block_allocator_core #(
  parameter int unsigned TopOrder    = bba_pkg::TopOrderDefault,
  parameter int unsigned LeastOrder  = bba_pkg::LeastOrderDefault,
  parameter int unsigned HeaderBytes = bba_pkg::HeaderBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  bba_pkg::req_t      req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output bba_pkg::rsp_t      rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import bba_pkg::*;

  localparam int unsigned Levels = TopOrder - LeastOrder + 1;
  localparam int unsigned NodeW  = Levels;          // node index bits
  localparam int unsigned Nodes  = (1 << Levels) - 1;
  localparam int unsigned LeafW  = Levels - 1;
  localparam int unsigned Leaves = 1 << LeafW;
  localparam logic [5:0] TopO    = 6'(TopOrder);
  localparam logic [5:0] LeastO  = 6'(LeastOrder);

  state_e state_q, state_d;
  logic [31:0] base_q;
  logic        func_q;
  logic [5:0]  need_q, need_d;
  logic [5:0]  ord_q, ord_d;        // current order in scan, split or merge
  logic [TopOrder:0] off_q, off_d;  // byte offset of current block
  logic [NodeW:0] clr_q, clr_d;
  rsp_t rsp_q, rsp_d;
  logic [31:0] addr_q;

  // tree memory ports
  logic t_we, t_wd, t_rd;
  logic [NodeW-1:0] t_wa, t_ra;
  // leaf memory ports
  logic l_we;
  logic [LeafW-1:0] l_wa, l_ra;
  logic [5:0] l_wd, l_rd;

  bba_tree_mem #(.Nodes(Nodes), .AddrW(NodeW)) u_tree (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );
  bba_leaf_mem #(.Leaves(Leaves), .AddrW(LeafW)) u_leaf (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd)
  );

  // node index of block at order o and offset
  function automatic logic [NodeW-1:0] node_at(input logic [5:0] o,
                                                input logic [TopOrder:0] off);
    logic [NodeW:0] lvl, idx;
    lvl = (NodeW+1)'(1) << (TopO - o);
    idx = (NodeW+1)'(off >> o);
    return NodeW'(lvl - 1 + idx);
  endfunction

  // combinational helpers
  logic [32:0] sum;
  logic [5:0]  lg;
  logic [31:0] foff;
  logic [TopOrder:0] buddy;
  logic [TopOrder:0] blk;
  always_comb begin
    sum   = 33'(req_i.request_size) + 33'(HeaderBytes);
    lg    = flog2(sum);
    foff  = req_i.release_address - 32'(HeaderBytes) - base_q;
    buddy = off_q ^ ((TopOrder+1)'(1) << ord_q);
    blk   = (TopOrder+1)'(1) << ord_q;
  end

  assign req_ready_o = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = (state_q == StOut);
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q;
    need_d  = need_q;
    ord_d   = ord_q;
    off_d   = off_q;
    clr_d   = clr_q;
    rsp_d   = rsp_q;
    t_we = 1'b0; t_wd = 1'b0; t_wa = '0; t_ra = node_at(ord_q, off_q);
    l_we = 1'b0; l_wd = '0; l_wa = LeafW'(off_q >> LeastOrder);
    l_ra = LeafW'(off_q >> LeastOrder);
    case (state_q)
      StClear: begin
        // clear all nodes, root set; clear leaf records
        t_we = 1'b1;
        t_wa = NodeW'(clr_q);
        t_wd = (clr_q == '0);
        l_we = (clr_q < (NodeW+1)'(Leaves));
        l_wa = LeafW'(clr_q);
        l_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (NodeW+1)'(Nodes - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (req_valid_i) begin
          rsp_d = '0;
          rsp_d.status = StatusOk;
          if (req_i.func == FuncAlloc) begin
            need_d = (lg < LeastO) ? LeastO : lg;
            ord_d  = (lg < LeastO) ? LeastO : lg;
            off_d  = '0;
            if (lg > TopO) begin
              rsp_d.status = StatusNoSpace;
              state_d = StOut;
            end else begin
              state_d = StScanRd;
            end
          end else begin
            off_d = foff[TopOrder:0];
            if (foff >= 32'(1 << TopOrder) || foff[LeastOrder-1:0] != '0) begin
              rsp_d.status = StatusBadFree;
              state_d = StOut;
            end else begin
              state_d = StFreeRd;
            end
          end
        end
      end
      StScanRd: begin
        // memory read of node (ord_q, off_q) issued this cycle
        state_d = StScanChk;
      end
      StScanChk: begin
        if (t_rd) begin
          t_we = 1'b1; t_wa = node_at(ord_q, off_q); t_wd = 1'b0;
          state_d = StSplit;
        end else if (off_q + blk >= (TopOrder+1)'(1 << TopOrder)) begin
          if (ord_q == TopO) begin
            rsp_d.status = StatusNoSpace;
            state_d = StOut;
          end else begin
            ord_d = ord_q + 1'b1;
            off_d = '0;
            state_d = StScanRd;
          end
        end else begin
          off_d = off_q + blk;
          state_d = StScanRd;
        end
        t_ra = node_at(ord_d, off_d);
      end
      StSplit: begin
        if (ord_q > need_q) begin
          t_we = 1'b1;
          t_wd = 1'b1;
          t_wa = node_at(ord_q - 1'b1, off_q + ((TopOrder+1)'(1) << (ord_q - 1'b1)));
          ord_d = ord_q - 1'b1;
        end else begin
          state_d = StAllocDone;
        end
      end
      StAllocDone: begin
        l_we = 1'b1;
        l_wd = {1'b1, need_q[4:0]};
        rsp_d.granted_address = base_q + 32'(off_q) + 32'(HeaderBytes);
        rsp_d.block_order = need_q[4:0];
        state_d = StOut;
      end
      StFreeRd: state_d = StFreeChk;
      StFreeChk: begin
        if (!l_rd[5]) begin
          rsp_d.status = StatusBadFree;
          state_d = StOut;
        end else begin
          l_we = 1'b1;
          l_wd = '0;
          ord_d = (l_rd[4:0] < LeastO[4:0] || {1'b0, l_rd[4:0]} > TopO) ? LeastO
                                                                         : {1'b0, l_rd[4:0]};
          state_d = StMergeRd;
        end
      end
      StMergeRd: begin
        t_ra = node_at(ord_q, buddy);
        if (ord_q == TopO) state_d = StFreeDone;
        else state_d = StMergeChk;
      end
      StMergeChk: begin
        if (t_rd) begin
          t_we = 1'b1; t_wa = node_at(ord_q, buddy); t_wd = 1'b0;
          off_d = off_q & ~blk;
          ord_d = ord_q + 1'b1;
          state_d = StMergeRd;
        end else begin
          state_d = StFreeDone;
        end
      end
      StFreeDone: begin
        t_we = 1'b1; t_wa = node_at(ord_q, off_q); t_wd = 1'b1;
        rsp_d.block_order = ord_q[4:0];
        state_d = StOut;
      end
      StOut: begin
        if (rsp_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i) base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    ord_q  <= ord_d;
    off_q  <= off_d;
    rsp_q  <= rsp_d;
    if (req_valid_i && req_ready_o) begin
      func_q <= req_i.func;
      addr_q <= req_i.release_address;
    end
  end

`ifndef SYNTHESIS
  // a failed result never carries an address or order
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StatusOk |-> rsp_o.granted_address == '0
      && rsp_o.block_order == '0) else $error("failed result not zeroed");
  // free results never carry an address
  a_free_noaddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && func_q == FuncFree |-> rsp_o.granted_address == '0
      && rsp_o.status != StatusNoSpace) else $error("bad free result");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o) && $stable(addr_q))
    else $error("result changed under stall");
`endif
endmodule
